@@ hw/rtl/dsdc_pkg.sv @@
`timescale 1ns / 1ps
package dsdc_pkg;

  localparam int unsigned DutyW   = 10;
  localparam int unsigned PowerW  = 32;
  localparam int unsigned GainW   = 16;
  localparam int unsigned PmaxW   = 31;
  localparam int unsigned MagW    = 33;
  localparam int unsigned ProdW   = MagW + GainW;   // error * gain
  localparam int unsigned ScaledW = ProdW + 4;      // times 10
  localparam int unsigned RemW    = PmaxW + 8;      // below 200 * max_power
  localparam int unsigned QuotW   = 8;
  localparam int unsigned DivStages = QuotW;

  localparam logic [1:0] REG_IMPORT = 2'd0;
  localparam logic [1:0] REG_EXPORT = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;
  localparam logic [1:0] REG_PMAX   = 2'd3;

  localparam logic signed [PowerW-1:0] ImportLimit  = 32'sd50000;
  localparam logic signed [PowerW-1:0] ExportLimit  = -32'sd50000;
  localparam logic [GainW-1:0]         GainDefault  = 16'd50;
  localparam logic [PmaxW-1:0]         PmaxDefault  = 31'd2300000;
  localparam logic [QuotW-1:0]         StepCap      = 8'd200;
  localparam logic [DutyW-1:0]         DutyFull     = 10'd1000;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_DEC  = 2'd1,
    DIR_INC  = 2'd2
  } dir_t;

  typedef struct packed {
    logic signed [PowerW-1:0] imp;
    logic signed [PowerW-1:0] exp_th;
    logic signed [PowerW:0]   target;
    logic [GainW-1:0]         gain;
    logic [PmaxW-1:0]         pmax;
    logic [RemW-1:0]          cap;    // 200 * pmax
  } norm_cfg_t;

  typedef struct packed {
    logic             sat;
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] quot;
    logic [DutyW-1:0] duty;
    dir_t             dir;
  } div_item_t;

endpackage

@@ hw/rtl/dsdc_cfg.sv @@
`timescale 1ns / 1ps
module dsdc_cfg
  import dsdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output norm_cfg_t   ncfg
);

  logic signed [PowerW-1:0] imp_r, exp_r;
  logic [GainW-1:0]         gain_r;
  logic [PmaxW-1:0]         pmax_r;
  norm_cfg_t                ncfg_r, ncfg_nxt;

  logic signed [PowerW-1:0] hi, lo;
  logic signed [PowerW:0]   sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imp_r  <= ImportLimit;
      exp_r  <= ExportLimit;
      gain_r <= GainDefault;
      pmax_r <= PmaxDefault;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMPORT: imp_r  <= cfg_wdata;
        REG_EXPORT: exp_r  <= cfg_wdata;
        REG_GAIN:   gain_r <= cfg_wdata[GainW-1:0];
        REG_PMAX:   pmax_r <= cfg_wdata[PmaxW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    hi = (imp_r < exp_r) ? exp_r : imp_r;
    lo = (imp_r < exp_r) ? imp_r : exp_r;
    if (lo > ExportLimit) lo = ExportLimit;
    if (hi < ImportLimit) hi = ImportLimit;
    sum = {hi[PowerW-1], hi} + {lo[PowerW-1], lo};
    ncfg_nxt.imp    = hi;
    ncfg_nxt.exp_th = lo;
    // halve, truncating toward zero
    ncfg_nxt.target = $signed(sum + {{PowerW{1'b0}}, sum[PowerW]}) >>> 1;
    ncfg_nxt.gain   = (gain_r == '0) ? GainDefault : gain_r;
    ncfg_nxt.pmax   = (pmax_r == '0) ? PmaxDefault : pmax_r;
    // cap is computed from the registered normalized pmax, so it settles in the cycle after pmax
    ncfg_nxt.cap    = RemW'(ncfg_r.pmax) * RemW'(StepCap);
  end

  always_ff @(posedge clk) begin
    ncfg_r <= ncfg_nxt;
  end

  assign ncfg = ncfg_r;

endmodule

@@ hw/rtl/dsdc_front.sv @@
`timescale 1ns / 1ps
module dsdc_front
  import dsdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  norm_cfg_t                ncfg,
  input  logic                     in_valid,
  input  logic [DutyW-1:0]         in_duty,
  input  logic signed [PowerW-1:0] in_grid,
  output logic                     out_valid,
  output div_item_t                out_item
);

  // stage 1: direction and error magnitude
  logic [2:0]         v_r;
  logic [MagW-1:0]    mag_r;
  logic [ProdW-1:0]   prod_r;
  logic [ScaledW-1:0] scaled_r;
  logic [DutyW-1:0]   duty_r [3];
  dir_t               dir_r  [3];
  dir_t               dir_nxt;
  logic signed [MagW-1:0] diff;
  logic [MagW-1:0]    mag_nxt;
  div_item_t          item_r, item_nxt;
  logic               v4_r;

  always_comb begin
    diff    = {in_grid[PowerW-1], in_grid} - ncfg.target;
    mag_nxt = diff[MagW-1] ? MagW'(-diff) : MagW'(diff);
    if (in_duty != '0 && in_grid >= ncfg.imp)
      dir_nxt = DIR_DEC;
    else if (in_grid <= ncfg.exp_th)
      dir_nxt = DIR_INC;
    else
      dir_nxt = DIR_HOLD;
  end

  always_comb begin
    item_nxt.sat  = ({2'b0, scaled_r} >= ScaledW'(ncfg.cap)) || (scaled_r >= ScaledW'(ncfg.cap));
    item_nxt.rem  = scaled_r[RemW-1:0];
    item_nxt.quot = '0;
    item_nxt.duty = duty_r[2];
    item_nxt.dir  = dir_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v_r  <= {v_r[1:0], in_valid};
      v4_r <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r     <= mag_nxt;
      duty_r[0] <= in_duty;
      dir_r[0]  <= dir_nxt;
      prod_r    <= ProdW'(mag_r) * ProdW'(ncfg.gain);
      duty_r[1] <= duty_r[0];
      dir_r[1]  <= dir_r[0];
      scaled_r  <= (ScaledW'(prod_r) << 3) + (ScaledW'(prod_r) << 1);
      duty_r[2] <= duty_r[1];
      dir_r[2]  <= dir_r[1];
      item_r    <= item_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = item_r;

endmodule

@@ hw/rtl/dsdc_div.sv @@
`timescale 1ns / 1ps
module dsdc_div
  import dsdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [PmaxW-1:0] pmax,
  input  logic             in_valid,
  input  div_item_t        in_item,
  output logic             out_valid,
  output logic [QuotW-1:0] out_step,
  output logic [DutyW-1:0] out_duty,
  output dir_t             out_dir
);

  logic      v_r  [DivStages];
  div_item_t st_r [DivStages];

  // one restoring step: quotient bit k
  function automatic div_item_t div_step(div_item_t it, logic [PmaxW-1:0] d, int k);
    logic [RemW-1:0] dk;
    div_item_t       o;
    dk = RemW'(d) << k;
    o  = it;
    if (!it.sat && it.rem >= dk) begin
      o.rem     = it.rem - dk;
      o.quot[k] = 1'b1;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DivStages; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < DivStages; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= div_step(in_item, pmax, QuotW - 1);
      for (int i = 1; i < DivStages; i++)
        st_r[i] <= div_step(st_r[i-1], pmax, QuotW - 1 - i);
    end
  end

  assign out_valid = v_r[DivStages-1];
  assign out_step  = st_r[DivStages-1].sat ? StepCap : st_r[DivStages-1].quot;
  assign out_duty  = st_r[DivStages-1].duty;
  assign out_dir   = st_r[DivStages-1].dir;

endmodule

@@ hw/rtl/deadband_step_duty_controller_top.sv @@
`timescale 1ns / 1ps
// Deadband step duty controller.
// Input items (in_*): present duty and measured grid power; one result item
// (out_*) with the new duty per input item, in order.
// Configuration: cfg_we/cfg_addr/cfg_wdata write import threshold (0), export
// threshold (1), gain (2) and max power (3); write only while no item is in
// flight, and allow the normalized copy (ncfg, then its cap) to settle before
// the next item.
// Pipeline: 13 register stages, taking one item per cycle unless stalled:
// 4 front stages (error, multiply by gain, scale by 10, saturation check),
// 8 restoring divide stages (one quotient bit each) and the output register.
// Stall: when out_tvalid is high and out_tready low, the whole pipeline
// holds and in_tready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous): pipeline emptied, registers return to
// 50000 / -50000 / 50 / 2300000.
module deadband_step_duty_controller_top
  import dsdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [9:0] present_duty, [41:10] grid_power
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] new_duty
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  norm_cfg_t        ncfg;
  logic             adv;
  logic             fr_valid, dv_valid;
  div_item_t        fr_item;
  logic [QuotW-1:0] dv_step;
  logic [DutyW-1:0] dv_duty;
  dir_t             dv_dir;
  logic             ov_r;
  logic [DutyW-1:0] duty_r, duty_nxt;
  logic [DutyW:0]   sum;
  logic [DutyW-1:0] dec;

  // whole pipeline advances unless a finished item waits
  assign adv       = !ov_r || out_tready;
  assign in_tready = adv;

  dsdc_cfg u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .ncfg
  );

  dsdc_front u_front (
    .clk, .rst_n, .adv, .ncfg,
    .in_valid (in_tvalid),
    .in_duty  (in_tdata[DutyW-1:0]),
    .in_grid  (in_tdata[DutyW+PowerW-1:DutyW]),
    .out_valid(fr_valid),
    .out_item (fr_item)
  );

  dsdc_div u_div (
    .clk, .rst_n, .adv,
    .pmax     (ncfg.pmax),
    .in_valid (fr_valid),
    .in_item  (fr_item),
    .out_valid(dv_valid),
    .out_step (dv_step),
    .out_duty (dv_duty),
    .out_dir  (dv_dir)
  );

  // apply step and clamp to 0..1000; an over-range duty lowered by a small
  // step still lands at full scale
  always_comb begin
    sum = {1'b0, dv_duty} + (DutyW+1)'(dv_step);
    dec = dv_duty - DutyW'(dv_step);
    case (dv_dir)
      DIR_DEC: duty_nxt = ((DutyW+1)'(dv_step) > {1'b0, dv_duty}) ? '0
                          : ((dec > DutyFull) ? DutyFull : dec);
      DIR_INC: duty_nxt = (sum > (DutyW+1)'(DutyFull)) ? DutyFull : sum[DutyW-1:0];
      default: duty_nxt = (dv_duty > DutyFull) ? DutyFull : dv_duty;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) duty_r <= duty_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(16-DutyW){1'b0}}, duty_r};

`ifndef ASSERT_OFF
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DutyW-1:0] <= DutyFull)
    else $error("new duty above full scale");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready not tied to output stall");
`endif

endmodule
